// ===== hdl/wvf_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and state codes of the window variation flag unit
package wvf_pkg;

    localparam int WINDOW       = 8;
    localparam int MIN_SAMPLES  = 3;
    localparam int SAMPLE_W     = 16;
    localparam int PCT_W        = 7;
    localparam int HELD_W       = 4;
    localparam int SLOT_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W        = $clog2(WINDOW + 1);
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW);
    localparam int SQ_W         = 2 * SAMPLE_W + $clog2(WINDOW);
    localparam int PROD_W       = 2 * SUM_W;
    localparam int PCT_SQ_W     = 14;
    localparam int CMP_W        = PROD_W + PCT_SQ_W;
    localparam int PCT_SCALE_SQ = 10000;
    localparam int PCT_RESET    = 30;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 8;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  square_sum;
    } queue_entry_t;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_SQUARE = 3'b010,
        F_PUSH   = 3'b100
    } front_state_t;

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_MUL    = 5'b00010,
        B_SPREAD = 5'b00100,
        B_SCALE  = 5'b01000,
        B_DECIDE = 5'b10000
    } back_state_t;

endpackage

// ===== hdl/wvf_front.sv =====
`timescale 1ns / 1ps
// front end: accepts samples, keeps the ring and the running sums, queues window totals
module wvf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wvf_pkg::IN_DATA_W-1:0]     s_tdata,   // [15:0] height_sample
    input  logic                              q_full,
    output logic                              q_push,
    output wvf_pkg::queue_entry_t             q_entry
);
    import wvf_pkg::*;

    front_state_t          state_reg, state_next;
    logic [SAMPLE_W-1:0]   ring_reg [WINDOW];
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SQ_W-1:0]       sumsq_reg, sumsq_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [SAMPLE_W-1:0]   old_reg;
    logic [2*SAMPLE_W-1:0] sq_new_reg, sq_new_next;
    logic [2*SAMPLE_W-1:0] sq_old_reg, sq_old_next;
    logic                  accept;
    logic                  full_window;

    assign s_tready    = (state_reg == F_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign full_window = (fill_reg == CNT_W'(WINDOW));

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        sumsq_next  = sumsq_reg;
        sample_next = sample_reg;
        sq_new_next = sq_new_reg;
        sq_old_next = sq_old_reg;
        q_push      = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    fill_next   = full_window ? fill_reg : fill_reg + 1'b1;
                    slot_next   = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    state_next  = F_SQUARE;
                end
            end
            F_SQUARE:
            begin
                sum_next    = sum_reg - SUM_W'(old_reg) + SUM_W'(sample_reg);
                sq_new_next = (2*SAMPLE_W)'(sample_reg) * (2*SAMPLE_W)'(sample_reg);
                sq_old_next = (2*SAMPLE_W)'(old_reg) * (2*SAMPLE_W)'(old_reg);
                state_next  = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    sumsq_next = sumsq_reg - SQ_W'(sq_old_reg) + SQ_W'(sq_new_reg);
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_entry.count      = fill_reg;
    assign q_entry.sum        = sum_reg;
    assign q_entry.square_sum = sumsq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        sq_new_reg <= sq_new_next;
        sq_old_reg <= sq_old_next;
        if (accept)
        begin
            // oldest sample leaves only once the window is full
            old_reg            <= full_window ? ring_reg[slot_reg] : '0;
            ring_reg[slot_reg] <= s_tdata[SAMPLE_W-1:0];
        end
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_fill_grows_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full_window) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance on a transfer");

endmodule

// ===== hdl/wvf_queue.sv =====
`timescale 1ns / 1ps
// short queue of window totals between front and back end
module wvf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wvf_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output wvf_pkg::queue_entry_t head,
    output logic                  empty
);
    import wvf_pkg::*;

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

// ===== hdl/wvf_back.sv =====
`timescale 1ns / 1ps
// back end: variation test on queued window totals and the output register
module wvf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  wvf_pkg::queue_entry_t          q_head,
    output logic                           q_pop,
    input  logic [wvf_pkg::PCT_W-1:0]      threshold,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wvf_pkg::OUT_DATA_W-1:0] m_tdata   // [0] low_confidence, [4:1] samples_held
);
    import wvf_pkg::*;

    back_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]     sumsq_reg, sumsq_next;
    logic [PROD_W-1:0]   nsq_reg, nsq_next;
    logic [PROD_W-1:0]   sum_sq_reg, sum_sq_next;
    logic [PCT_SQ_W-1:0] pct_sq_reg, pct_sq_next;
    logic [PROD_W-1:0]   spread_reg, spread_next;
    logic [CMP_W-1:0]    lhs_reg, lhs_next;
    logic [CMP_W-1:0]    rhs_reg, rhs_next;
    logic                flag_reg, flag_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;
    logic                enough;

    assign out_free = !out_valid_reg || m_tready;
    assign enough   = (n_reg >= CNT_W'(MIN_SAMPLES));

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        nsq_next       = nsq_reg;
        sum_sq_next    = sum_sq_reg;
        pct_sq_next    = pct_sq_reg;
        spread_next    = spread_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        flag_next      = flag_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    n_next     = q_head.count;
                    sum_next   = q_head.sum;
                    sumsq_next = q_head.square_sum;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                nsq_next    = PROD_W'(n_reg) * PROD_W'(sumsq_reg);
                sum_sq_next = PROD_W'(sum_reg) * PROD_W'(sum_reg);
                pct_sq_next = PCT_SQ_W'(threshold) * PCT_SQ_W'(threshold);
                state_next  = B_SPREAD;
            end
            B_SPREAD:
            begin
                // n*sumsq never falls below sum^2
                spread_next = nsq_reg - sum_sq_reg;
                state_next  = B_SCALE;
            end
            B_SCALE:
            begin
                lhs_next   = CMP_W'(spread_reg) * CMP_W'(PCT_SCALE_SQ);
                rhs_next   = CMP_W'(pct_sq_reg) * CMP_W'(sum_sq_reg);
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                if (out_free)
                begin
                    // below three samples the flag holds its last value
                    if (enough)
                    begin
                        flag_next = (sum_reg != '0) && (lhs_reg > rhs_reg);
                    end
                    held_next      = HELD_W'(n_reg);
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        sum_reg    <= sum_next;
        sumsq_reg  <= sumsq_next;
        nsq_reg    <= nsq_next;
        sum_sq_reg <= sum_sq_next;
        pct_sq_reg <= pct_sq_next;
        spread_reg <= spread_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        held_reg   <= held_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - HELD_W - 1)'(0), held_reg, flag_reg};

    a_zero_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DECIDE && out_free && enough && sum_reg == '0) |=> !flag_reg)
        else $error("flag set on an all-zero window");

    a_flag_held_early: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DECIDE && out_free && !enough) |=> (flag_reg == $past(flag_reg)))
        else $error("flag changed with fewer than three samples");

endmodule

// ===== hdl/window_variation_flag_unit.sv =====
`timescale 1ns / 1ps
// top level of the window variation flag unit
// Each height sample (16-bit unsigned Q12.4) enters a window of the last eight samples and
// yields one result: the low-confidence flag and the number of samples held. The flag is
// set when the window's coefficient of variation exceeds the programmed percentage, tested
// exactly as 10000*(n*sumsq - sum^2) > pct^2*sum^2; it is 0 for an all-zero window and keeps
// its last value while fewer than three samples are held. The front end takes a new sample
// only after its square and push states, updating the ring and running sums; the back end
// steps through queue pop, multiply, subtract, scale and compare for each total, takes no new
// one before it ends and so sets the sustained rate. A two-entry queue between them and the
// output register absorb a short output stall; a longer one fills the queue and then holds
// s_tready low until results drain. The user must write the threshold through the cfg channel
// only while no transfer is in flight; the block does not enforce this. It resets to 30 percent.
module window_variation_flag_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wvf_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] height_sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wvf_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] low_confidence, [4:1] samples_held
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wvf_pkg::PCT_W-1:0]      cfg_data   // [6:0] cv_threshold_percent
);
    import wvf_pkg::*;

    logic [PCT_W-1:0] threshold_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    queue_entry_t     push_entry;
    queue_entry_t     head_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= PCT_W'(PCT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    wvf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    wvf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head_entry),
        .empty      (q_empty)
    );

    wvf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_entry),
        .q_pop     (q_pop),
        .threshold (threshold_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/tb_window_variation_flag_unit.sv =====
`timescale 1ns / 1ps
// testbench of the window variation flag unit: predicted flags checked against every output transfer
module tb_window_variation_flag_unit;
    import wvf_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 148;
    localparam int MAX_REPORTS  = 50;

    typedef struct {
        bit       low_confidence;
        bit [3:0] samples_held;
    } flag_result_t;

    typedef enum int {
        RUN_STEADY,
        RUN_UNIFORM,
        RUN_ZERO,
        RUN_EXTREME
    } run_kind_t;

    class flag_scoreboard;
        bit [SAMPLE_W-1:0] ring [WINDOW];
        int unsigned       next_slot;
        int unsigned       held;
        longint unsigned   sum;
        longint unsigned   square_sum;
        bit                flag;
        bit [PCT_W-1:0]    threshold_pct;
        flag_result_t      expected_flags [$];
        int                errors;

        function new();
            next_slot     = 0;
            held          = 0;
            sum           = 0;
            square_sum    = 0;
            flag          = 1'b0;
            threshold_pct = PCT_W'(PCT_RESET);
            errors        = 0;
        endfunction

        function void set_threshold(bit [PCT_W-1:0] pct);
            threshold_pct = pct;
        endfunction

        // exact form of std/mean > pct/100, zero when the window sums to zero
        function bit spread_over_limit();
            longint unsigned sum_sq;
            longint unsigned spread;
            longint unsigned pct;
            if (sum == 0)
                return 1'b0;
            pct    = threshold_pct;
            sum_sq = sum * sum;
            spread = longint'(held) * square_sum - sum_sq;
            return longint'(PCT_SCALE_SQ) * spread > pct * pct * sum_sq;
        endfunction

        function void note_sample(bit [SAMPLE_W-1:0] sample);
            flag_result_t    res;
            longint unsigned old;
            longint unsigned s;
            s = sample;
            if (held >= WINDOW)
            begin
                old        = ring[next_slot];
                sum        = sum - old;
                square_sum = square_sum - old * old;
            end
            else
                held++;
            ring[next_slot] = sample;
            sum             = sum + s;
            square_sum      = square_sum + s * s;
            next_slot       = (next_slot + 1) % WINDOW;
            if (held >= MIN_SAMPLES)
                flag = spread_over_limit();
            res.low_confidence = flag;
            res.samples_held   = held[3:0];
            expected_flags.insert(expected_flags.size(), res);
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(bit [OUT_DATA_W-1:0] data);
            flag_result_t want;
            if (expected_flags.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual 0x%02h",
                             $time, data);
                return;
            end
            want = expected_flags.pop_front();
            if (data[0] !== want.low_confidence)
                report("low_confidence", want.low_confidence, data[0]);
            if (data[4:1] !== want.samples_held)
                report("samples_held", want.samples_held, data[4:1]);
            if (data[OUT_DATA_W-1:5] !== '0)
                report("padding", 0, data[OUT_DATA_W-1:5]);
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [PCT_W-1:0]      cfg_data  = '0;

    flag_scoreboard sb = new();
    bit             idle_on       = 1'b1;
    bit             long_hold_req = 1'b0;

    window_variation_flag_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // every transfer seen at the edge where it happens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                sb.set_threshold(cfg_data);
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_sample(input bit [SAMPLE_W-1:0] sample);
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic sender_gap(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input bit [PCT_W-1:0] pct);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= pct;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [SAMPLE_W-1:0] pick_sample(run_kind_t kind, int base, int jitter);
        int v;
        case (kind)
            RUN_UNIFORM:
                return SAMPLE_W'($urandom);
            RUN_ZERO:
                return ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom_range(0, 3)) : '0;
            RUN_EXTREME:
                return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:
            begin
                v = base + int'($urandom_range(0, 2 * jitter)) - jitter;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return v[SAMPLE_W-1:0];
            end
        endcase
    endfunction

    // runs of steady, uniform, near-zero or extreme samples; steady runs land the variation near the threshold
    task automatic random_samples(input int count);
        int        sent;
        int        run_len;
        int        base;
        int        jitter;
        int        roll;
        run_kind_t kind;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(0, 9);
            kind = (roll < 6) ? RUN_STEADY : (roll < 8) ? RUN_UNIFORM :
                   (roll < 9) ? RUN_ZERO : RUN_EXTREME;
            base = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 255);
            jitter = base * $urandom_range(0, 2 * sb.threshold_pct + 10) / 100;
            run_len = $urandom_range(3, 20);
            if (run_len > count - sent)
                run_len = count - sent;
            repeat (run_len)
            begin
                if (idle_on && $urandom_range(0, 4) == 0)
                    sender_gap($urandom_range(1, 6));
                send_sample(pick_sample(kind, base, jitter));
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        bit [PCT_W-1:0] pct;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // under three samples the flag holds, then an all-zero window
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        // fill past the window so the zeros leave it
        repeat (7) send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        // zero threshold: constant window clear, any spread sets the flag
        write_threshold(PCT_W'(0));
        repeat (8) send_sample(16'd100);
        send_sample(16'd101);
        write_threshold(PCT_W'(127));
        send_sample(16'h0000);
        send_sample(16'hFFFF);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: pct = PCT_W'(0);
                1: pct = PCT_W'(127);
                2: pct = PCT_W'(100);
                3: pct = PCT_W'(30);
                4: pct = PCT_W'(1);
                default: pct = PCT_W'($urandom_range(0, 127));
            endcase
            write_threshold(pct);
            if (p == PHASES - 1)
                idle_on = 1'b0;
            if (p == 2)
                long_hold_req = 1'b1;
            if (p == 4)
            begin
                random_samples(PHASE_ITEMS / 2);
                wait_drained();
                random_samples(PHASE_ITEMS / 2);
            end
            else
                random_samples(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
